>>> hdl/lsc_pkg.sv
// ----------------------------------------------------------------------------
// lsc_pkg : shared types and constants for the line segment clipper
// Coordinate width, outcode bits, register indexes, word types, the controller
// state type, the command and status structs and the outcode function.
// ----------------------------------------------------------------------------
`default_nettype none
package lsc_pkg;
	localparam int COORD_BITS = 16;
	localparam int PROD_BITS  = 2 * (COORD_BITS + 1);
	localparam int MAG_BITS   = COORD_BITS + 1;
	localparam int MAX_MOVES  = 4;
	localparam int MOVE_BITS  = 3;
	localparam int DIV_CNT_BITS = $clog2(PROD_BITS + 1);

	localparam logic [3:0] CODE_LEFT   = 4'd1;
	localparam logic [3:0] CODE_RIGHT  = 4'd2;
	localparam logic [3:0] CODE_BOTTOM = 4'd4;
	localparam logic [3:0] CODE_TOP    = 4'd8;

	localparam logic [1:0] REG_X_MIN = 2'd0;
	localparam logic [1:0] REG_Y_MIN = 2'd1;
	localparam logic [1:0] REG_X_MAX = 2'd2;
	localparam logic [1:0] REG_Y_MAX = 2'd3;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		coord_t start_x;
		coord_t start_y;
		coord_t end_x;
		coord_t end_y;
	} seg_in_t;

	typedef struct packed {
		logic   accepted;
		coord_t clipped_start_x;
		coord_t clipped_start_y;
		coord_t clipped_end_x;
		coord_t clipped_end_y;
	} seg_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TEST,
		ST_MUL,
		ST_DIV,
		ST_UPDATE,
		ST_DONE
	} lsc_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic setup;
		logic div_start;
		logic update;
		logic finish;
	} lsc_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic trivial_acc;
		logic trivial_rej;
		logic div_done;
	} lsc_stat_t;

	function automatic logic [3:0] outcode(coord_t x, coord_t y, coord_t xl,
		coord_t yl, coord_t xh, coord_t yh);
		logic [3:0] c;
		c = 4'd0;
		if (x < xl) c |= CODE_LEFT;
		else if (x > xh) c |= CODE_RIGHT;
		if (y < yl) c |= CODE_BOTTOM;
		else if (y > yh) c |= CODE_TOP;
		return c;
	endfunction
endpackage
`default_nettype wire

>>> hdl/line_segment_clipper_unit.sv
// ----------------------------------------------------------------------------
// line_segment_clipper_unit : Cohen-Sutherland segment clipper
// A segment word is taken when start is high and busy low. The clipped
// word appears on result, marked by done for one cycle; the receiver cannot
// stall it. Window edges are written via cfg_we/cfg_idx/cfg_data, by the
// user only while idle; the block itself does not enforce this. Each clip
// move runs setup, multiply, serial divide and update, for up to four moves.
// One segment at a time; busy stays high until done. The serial divider
// sets the move cost. Reset restores the window 50..200 on both axes and
// idles the block. Rejected segments give accepted low and all coordinates
// zero.
// ----------------------------------------------------------------------------
`default_nettype none
module line_segment_clipper_unit import lsc_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_idx,
	input  wire coord_t     cfg_data,
	input  wire logic       start,
	input  wire seg_in_t    segment,
	output logic            busy,
	output logic            done,
	output seg_out_t        result
);
	lsc_cmd_t  cmd;
	lsc_stat_t stat;
	logic      go;

	assign go = start && !busy;

	lsc_control u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (go),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	lsc_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.seg      (segment),
		.cmd      (cmd),
		.stat     (stat),
		.res      (result)
	);
endmodule
`default_nettype wire

>>> hdl/lsc_divider.sv
// ----------------------------------------------------------------------------
// lsc_divider : restoring unsigned divider, one quotient bit per cycle
// Divides a PROD_BITS dividend by a MAG_BITS divisor; zero divisor gives 0.
// ----------------------------------------------------------------------------
`default_nettype none
module lsc_divider import lsc_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [PROD_BITS-1:0] dividend,
	input  wire logic [MAG_BITS-1:0]  divisor,
	output logic                      done,
	output logic [PROD_BITS-1:0]      quotient
);
	logic [PROD_BITS-1:0]    num_q;
	logic [MAG_BITS:0]       rem_q;
	logic [MAG_BITS-1:0]     den_q;
	logic [DIV_CNT_BITS-1:0] cnt_q;
	logic                    busy_q;
	logic [MAG_BITS:0]       trial;
	logic                    fits;

	// shift in next dividend bit and try subtract
	always_comb begin
		trial = {rem_q[MAG_BITS-1:0], num_q[PROD_BITS-1]};
		fits  = (den_q != '0) && (trial >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_BITS'(PROD_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	// datapath words
	always_ff @(posedge clk) begin
		if (start) begin
			num_q    <= dividend;
			den_q    <= divisor;
			rem_q    <= '0;
			quotient <= '0;
		end else if (busy_q) begin
			num_q    <= {num_q[PROD_BITS-2:0], 1'b0};
			rem_q    <= fits ? (trial - {1'b0, den_q}) : trial;
			quotient <= {quotient[PROD_BITS-2:0], fits};
		end
	end
endmodule
`default_nettype wire

>>> hdl/lsc_datapath.sv
// ----------------------------------------------------------------------------
// lsc_datapath : endpoint registers, outcodes, multiplier and divider
// Holds the window and current segment; computes one edge intersection per
// command sequence from the controller.
// ----------------------------------------------------------------------------
`default_nettype none
module lsc_datapath import lsc_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     cfg_we,
	input  wire logic [1:0] cfg_idx,
	input  wire coord_t   cfg_data,
	input  wire seg_in_t  seg,
	input  wire lsc_cmd_t cmd,
	output lsc_stat_t     stat,
	output seg_out_t      res
);
	coord_t xl_q, yl_q, xh_q, yh_q;
	coord_t x0_q, y0_q, x1_q, y1_q;
	logic [3:0] c0, c1, co;
	logic sel_end_q, vert_q, neg_q;
	coord_t edge_q, base_q;
	logic [MAG_BITS-1:0] mb_q, mn_q, md_q;
	logic [PROD_BITS-1:0] prod;
	logic [PROD_BITS-1:0] quot;
	logic div_done;

	// window registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xl_q <= coord_t'(50);
			yl_q <= coord_t'(50);
			xh_q <= coord_t'(200);
			yh_q <= coord_t'(200);
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_X_MIN: xl_q <= cfg_data;
				REG_Y_MIN: yl_q <= cfg_data;
				REG_X_MAX: xh_q <= cfg_data;
				REG_Y_MAX: yh_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		c0 = outcode(x0_q, y0_q, xl_q, yl_q, xh_q, yh_q);
		c1 = outcode(x1_q, y1_q, xl_q, yl_q, xh_q, yh_q);
		co = (c0 != 4'd0) ? c0 : c1;
		stat.trivial_acc = (c0 == 4'd0) && (c1 == 4'd0);
		stat.trivial_rej = (c0 & c1) != 4'd0;
		stat.div_done    = div_done;
	end

	// setup operands: differences on MAG_BITS signed values
	logic signed [MAG_BITS-1:0] a0, a1, b0, b1, ed, db, dn, dd;
	coord_t edge_sel;
	logic vert_sel;
	always_comb begin
		vert_sel = (co & (CODE_TOP | CODE_BOTTOM)) != 4'd0;
		if ((co & CODE_TOP) != 4'd0)         edge_sel = yh_q;
		else if ((co & CODE_BOTTOM) != 4'd0) edge_sel = yl_q;
		else if ((co & CODE_RIGHT) != 4'd0)  edge_sel = xh_q;
		else                                 edge_sel = xl_q;
		a0 = vert_sel ? MAG_BITS'(y0_q) : MAG_BITS'(x0_q);
		a1 = vert_sel ? MAG_BITS'(y1_q) : MAG_BITS'(x1_q);
		b0 = vert_sel ? MAG_BITS'(x0_q) : MAG_BITS'(y0_q);
		b1 = vert_sel ? MAG_BITS'(x1_q) : MAG_BITS'(y1_q);
		ed = MAG_BITS'(edge_sel);
		db = b1 - b0;
		dn = ed - a0;
		dd = a1 - a0;
	end

	// product of the set-up magnitudes, taken by the divider in the multiply cycle
	assign prod = mb_q * mn_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x0_q <= seg.start_x;
			y0_q <= seg.start_y;
			x1_q <= seg.end_x;
			y1_q <= seg.end_y;
		end else if (cmd.update) begin
			// base +/- quotient, truncated to coordinate width
			if (sel_end_q) begin
				if (vert_q) begin
					x1_q <= neg_q ? base_q - coord_t'(quot) : base_q + coord_t'(quot);
					y1_q <= edge_q;
				end else begin
					y1_q <= neg_q ? base_q - coord_t'(quot) : base_q + coord_t'(quot);
					x1_q <= edge_q;
				end
			end else begin
				if (vert_q) begin
					x0_q <= neg_q ? base_q - coord_t'(quot) : base_q + coord_t'(quot);
					y0_q <= edge_q;
				end else begin
					y0_q <= neg_q ? base_q - coord_t'(quot) : base_q + coord_t'(quot);
					x0_q <= edge_q;
				end
			end
		end
		if (cmd.setup) begin
			sel_end_q <= (c0 == 4'd0);
			vert_q    <= vert_sel;
			edge_q    <= edge_sel;
			base_q    <= coord_t'(b0);
			neg_q     <= db[MAG_BITS-1] ^ dn[MAG_BITS-1] ^ dd[MAG_BITS-1];
			mb_q      <= db[MAG_BITS-1] ? MAG_BITS'(-db) : MAG_BITS'(db);
			mn_q      <= dn[MAG_BITS-1] ? MAG_BITS'(-dn) : MAG_BITS'(dn);
			md_q      <= dd[MAG_BITS-1] ? MAG_BITS'(-dd) : MAG_BITS'(dd);
		end
	end

	lsc_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (prod),
		.divisor  (md_q),
		.done     (div_done),
		.quotient (quot)
	);

	// result register
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			res.accepted        <= stat.trivial_acc;
			res.clipped_start_x <= stat.trivial_acc ? x0_q : '0;
			res.clipped_start_y <= stat.trivial_acc ? y0_q : '0;
			res.clipped_end_x   <= stat.trivial_acc ? x1_q : '0;
			res.clipped_end_y   <= stat.trivial_acc ? y1_q : '0;
		end
	end
endmodule
`default_nettype wire

>>> hdl/lsc_control.sv
// ----------------------------------------------------------------------------
// lsc_control : sequencer for the clip loop
// Tests outcodes, then runs multiply and divide for each move, at most four.
// ----------------------------------------------------------------------------
`default_nettype none
module lsc_control import lsc_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	input  wire lsc_stat_t stat,
	output lsc_cmd_t       cmd,
	output logic           busy,
	output logic           done
);
	lsc_state_t state_q, state_d;
	logic [MOVE_BITS-1:0] moves_q;
	logic end_loop;

	assign end_loop = stat.trivial_acc || stat.trivial_rej ||
		(moves_q >= MOVE_BITS'(MAX_MOVES));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (start) state_d = ST_TEST;
			ST_TEST:   state_d = end_loop ? ST_DONE : ST_MUL;
			ST_MUL:    state_d = ST_DIV;
			ST_DIV:    if (stat.div_done) state_d = ST_UPDATE;
			ST_UPDATE: state_d = ST_TEST;
			ST_DONE:   state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd  = '0;
		busy = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE:   cmd.load = start;
			ST_TEST: begin
				cmd.setup  = !end_loop;
				cmd.finish = end_loop;
			end
			ST_MUL:    cmd.div_start = 1'b1;
			ST_UPDATE: cmd.update = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			moves_q <= '0;
			done    <= 1'b0;
		end else begin
			state_q <= state_d;
			done    <= (state_q == ST_TEST) && end_loop;
			if (state_q == ST_IDLE) moves_q <= '0;
			else if (state_q == ST_UPDATE) moves_q <= moves_q + 1'b1;
		end
	end
endmodule
`default_nettype wire

>>> hdl/lsc_checker.sv
// ----------------------------------------------------------------------------
// lsc_checker : port-level checks for the clipper
// Watches handshake and result ports of the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module lsc_checker import lsc_pkg::*; (
	input wire logic     clk,
	input wire logic     arst_n,
	input wire logic     start,
	input wire logic     busy,
	input wire logic     done,
	input wire seg_out_t result
);
	// a taken word raises busy
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("busy not raised");
	// done only ends a busy spell
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("done without work");
	// done is a single-cycle strobe
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held");
	// rejected word carries zeros
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.accepted) |-> (result.clipped_start_x == '0 &&
		result.clipped_start_y == '0 && result.clipped_end_x == '0 &&
		result.clipped_end_y == '0)) else $error("reject not zero");
endmodule

bind line_segment_clipper_unit lsc_checker u_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb : self-checking bench for line_segment_clipper_unit
// Segment words go in through the start/busy handshake under random gaps,
// and each done word is checked field by field against the row's written
// expected word or a clipping model kept in this bench. The window is rewritten between phases, covering
// the reset window, full range, degenerate and inverted windows.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
	import lsc_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 200;

	logic     clk, arst_n, cfg_we, start;
	logic [1:0] cfg_idx;
	coord_t   cfg_data;
	seg_in_t  segment;
	logic     busy, done;
	seg_out_t result;

	// bench copy of the window registers: left, bottom, right, top
	longint   win_xl, win_yl, win_xh, win_yh;
	seg_out_t expected_words[$];
	int       fail_count, idle_cycles, items_sent;

	typedef struct {
		seg_in_t  seg;
		logic     typed;  // expected word written in the row
		seg_out_t want;
	} stim_row_t;

	line_segment_clipper_unit DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .start(start), .segment(segment), .busy(busy),
		.done(done), .result(result)
	);

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	// ---- clipping model ----
	function automatic logic [3:0] region_code(longint x, longint y);
		logic [3:0] c;
		c = 4'd0;
		if (x < win_xl) c |= CODE_LEFT;
		else if (x > win_xh) c |= CODE_RIGHT;
		if (y < win_yl) c |= CODE_BOTTOM;
		else if (y > win_yh) c |= CODE_TOP;
		return c;
	endfunction

	// b0 + (b1-b0)*(e-a0)/(a1-a0), quotient truncated toward zero
	function automatic longint edge_cross(longint a0, longint b0, longint a1,
		longint b1, longint e);
		longint db, num, den, q;
		db = b1 - b0; num = e - a0; den = a1 - a0;
		if (den == 0) return b0;
		q = ((db < 0) ? -db : db) * ((num < 0) ? -num : num) / ((den < 0) ? -den : den);
		return (((db < 0) ^ (num < 0) ^ (den < 0)) != 0) ? b0 - q : b0 + q;
	endfunction

	function automatic seg_out_t clip_segment(seg_in_t s);
		longint x0, y0, x1, y1, nx, ny;
		logic [3:0] c0, c1, co;
		int moves;
		seg_out_t r;
		x0 = s.start_x; y0 = s.start_y; x1 = s.end_x; y1 = s.end_y;
		c0 = region_code(x0, y0); c1 = region_code(x1, y1);
		r = '0;
		for (moves = 0; moves <= MAX_MOVES; moves++) begin
			if (c0 == 4'd0 && c1 == 4'd0) begin
				r.accepted = 1'b1;
				r.clipped_start_x = coord_t'(x0); r.clipped_start_y = coord_t'(y0);
				r.clipped_end_x = coord_t'(x1); r.clipped_end_y = coord_t'(y1);
				break;
			end
			if ((c0 & c1) != 4'd0 || moves == MAX_MOVES) break;
			co = (c0 != 4'd0) ? c0 : c1;
			if ((co & CODE_TOP) != 0) begin
				nx = edge_cross(y0, x0, y1, x1, win_yh); ny = win_yh;
			end else if ((co & CODE_BOTTOM) != 0) begin
				nx = edge_cross(y0, x0, y1, x1, win_yl); ny = win_yl;
			end else if ((co & CODE_RIGHT) != 0) begin
				ny = edge_cross(x0, y0, x1, y1, win_xh); nx = win_xh;
			end else begin
				ny = edge_cross(x0, y0, x1, y1, win_xl); nx = win_xl;
			end
			if (c0 != 4'd0) begin
				x0 = nx; y0 = ny; c0 = region_code(x0, y0);
			end else begin
				x1 = nx; y1 = ny; c1 = region_code(x1, y1);
			end
		end
		return r;
	endfunction

	// ---- result checking ----
	task automatic report_field(string name, longint want, longint got);
		$display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
		fail_count++;
	endtask

	always @(posedge clk) begin
		seg_out_t w;
		if (arst_n && done) begin
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected word: expected none, actual %h", $time, result);
				fail_count++;
			end else begin
				w = expected_words.pop_front();
				if (result.accepted !== w.accepted)
					report_field("accepted", w.accepted, result.accepted);
				if (result.clipped_start_x !== w.clipped_start_x)
					report_field("clipped_start_x", w.clipped_start_x, result.clipped_start_x);
				if (result.clipped_start_y !== w.clipped_start_y)
					report_field("clipped_start_y", w.clipped_start_y, result.clipped_start_y);
				if (result.clipped_end_x !== w.clipped_end_x)
					report_field("clipped_end_x", w.clipped_end_x, result.clipped_end_x);
				if (result.clipped_end_y !== w.clipped_end_y)
					report_field("clipped_end_y", w.clipped_end_y, result.clipped_end_y);
			end
		end
	end

	// watchdog: cycles with neither a word taken nor a word returned
	always @(posedge clk) begin
		if (!arst_n || done || (start && !busy)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// ---- stimulus ----
	task automatic set_window(longint xl, longint yl, longint xh, longint yh);
		@(posedge clk);
		cfg_we <= 1'b1; cfg_idx <= REG_X_MIN; cfg_data <= coord_t'(xl);
		@(posedge clk);
		cfg_idx <= REG_Y_MIN; cfg_data <= coord_t'(yl);
		@(posedge clk);
		cfg_idx <= REG_X_MAX; cfg_data <= coord_t'(xh);
		@(posedge clk);
		cfg_idx <= REG_Y_MAX; cfg_data <= coord_t'(yh);
		@(posedge clk);
		cfg_we <= 1'b0;
		win_xl = xl; win_yl = yl; win_xh = xh; win_yh = yh;
	endtask

	// drain all outstanding words, then let the block settle
	task automatic wait_idle();
		@(posedge clk);
		start <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic send_segment(seg_in_t s, logic typed, seg_out_t want);
		segment <= s;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		expected_words.push_back(typed ? want : clip_segment(s));
		items_sent++;
		// random gaps, none in one long stretch
		if (!(items_sent >= 300 && items_sent < 500) && $urandom_range(99) < 31) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	function automatic coord_t rand_coord(longint lo, longint hi);
		longint a, b, v;
		if ($urandom_range(99) < 25) return coord_t'($urandom);
		a = (lo < hi) ? lo : hi; b = (lo < hi) ? hi : lo;
		a -= (b - a) / 2 + 20; b += (b - a) / 3 + 20;
		if (a < -32768) a = -32768;
		if (b > 32767) b = 32767;
		v = a + longint'({$urandom, $urandom} % 64'(b - a + 1));
		return coord_t'(v);
	endfunction

	function automatic seg_in_t mk_seg(longint x0, longint y0, longint x1, longint y1);
		seg_in_t s;
		s.start_x = coord_t'(x0); s.start_y = coord_t'(y0);
		s.end_x = coord_t'(x1); s.end_y = coord_t'(y1);
		return s;
	endfunction

	function automatic seg_out_t mk_word(logic a, longint x0, longint y0, longint x1,
		longint y1);
		seg_out_t w;
		w.accepted = a;
		w.clipped_start_x = coord_t'(x0); w.clipped_start_y = coord_t'(y0);
		w.clipped_end_x = coord_t'(x1); w.clipped_end_y = coord_t'(y1);
		return w;
	endfunction

	initial begin
		stim_row_t rows[$];
		seg_out_t none;
		longint wins[7][4];
		int p, n;
		none = '0;
		fail_count = 0; items_sent = 0;
		arst_n <= 1'b0; cfg_we <= 1'b0; cfg_idx <= REG_X_MIN; cfg_data <= '0;
		start <= 1'b0; segment <= '0;
		win_xl = 50; win_yl = 50; win_xh = 200; win_yh = 200;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part on the reset window
		rows.push_back('{mk_seg(60, 70, 150, 190), 1, mk_word(1, 60, 70, 150, 190)});
		rows.push_back('{mk_seg(50, 50, 200, 200), 1, mk_word(1, 50, 50, 200, 200)});
		rows.push_back('{mk_seg(0, 0, 10, 300), 1, none});        // both left
		rows.push_back('{mk_seg(300, 60, 400, 190), 1, none});    // both right
		rows.push_back('{mk_seg(60, 0, 190, 49), 1, none});       // both below
		rows.push_back('{mk_seg(60, 201, 190, 32767), 1, none});  // both above
		rows.push_back('{mk_seg(-32768, -32768, 32767, 32767), 0, none});
		rows.push_back('{mk_seg(32767, 32767, -32768, -32768), 0, none});
		rows.push_back('{mk_seg(-32768, 32767, 32767, -32768), 0, none});
		rows.push_back('{mk_seg(100, 100, 100, 32767), 0, none}); // vertical, top cut
		rows.push_back('{mk_seg(-32768, 120, 120, 120), 0, none});// horizontal, left cut
		rows.push_back('{mk_seg(0, 120, 120, 0), 0, none});       // crosses lower-left corner
		rows.push_back('{mk_seg(0, 100, 300, 150), 0, none});     // left then right cut
		rows.push_back('{mk_seg(100, 0, 150, 300), 0, none});     // bottom then top cut
		rows.push_back('{mk_seg(-1, -7, 251, 333), 0, none});     // truncation on negatives
		rows.push_back('{mk_seg(0, 260, 260, 0), 0, none});       // diagonal outside corner
		foreach (rows[i]) send_segment(rows[i].seg, rows[i].typed, rows[i].want);
		wait_idle();

		// inverted window: move bound and inverted outcodes
		set_window(200, 200, 50, 50);
		send_segment(mk_seg(100, 100, 120, 130), 0, none);
		send_segment(mk_seg(0, 0, 300, 300), 0, none);
		send_segment(mk_seg(0, 300, 300, 0), 0, none);
		send_segment(mk_seg(-32768, 32767, 32767, -32768), 0, none);
		wait_idle();

		// random phases over several windows
		wins = '{'{50, 50, 200, 200}, '{-32768, -32768, 32767, 32767},
			'{-100, -3000, 4000, 20}, '{10, 10, 10, 10}, '{300, 100, -300, -100},
			'{-32768, 32767, 32767, -32768}, '{0, 0, 0, 0}};
		for (p = 0; p < 7; p++) begin
			if (p == 6) begin
				wins[p][0] = $signed(coord_t'($urandom)); wins[p][1] = $signed(coord_t'($urandom));
				wins[p][2] = $signed(coord_t'($urandom)); wins[p][3] = $signed(coord_t'($urandom));
			end
			set_window(wins[p][0], wins[p][1], wins[p][2], wins[p][3]);
			for (n = 0; n < 170; n++)
				send_segment(mk_seg(rand_coord(win_xl, win_xh), rand_coord(win_yl, win_yh),
					rand_coord(win_xl, win_xh), rand_coord(win_yl, win_yh)), 0, none);
			wait_idle();
		end

		if (fail_count == 0 && expected_words.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
`default_nettype wire

>>> filelist.f
hdl/lsc_pkg.sv
hdl/lsc_divider.sv
hdl/lsc_datapath.sv
hdl/lsc_control.sv
hdl/line_segment_clipper_unit.sv
hdl/lsc_checker.sv
dv/tb.sv
